// File: rtl/crr_pkg.sv
// Package for the checksummed record receiver.
// Holds line characters, codes, the frame phase type and payload structs.
// No dependencies; the core and the frame state machine import it.
package crr_pkg;

  // Line control characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_CAN = 8'h18;

  // Request modes
  localparam logic [2:0] MODE_BYTE       = 3'd0;
  localparam logic [2:0] MODE_TIMEOUT    = 3'd1;
  localparam logic [2:0] MODE_ABORT_FILE = 3'd2;
  localparam logic [2:0] MODE_ABORT_ALL  = 3'd3;
  localparam logic [2:0] MODE_NEW_FILE   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_MSG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RETRY    = 3'd1;
  localparam logic [2:0] ST_MSGDONE  = 3'd2;
  localparam logic [2:0] ST_EOF      = 3'd3;
  localparam logic [2:0] ST_CANCEL   = 3'd4;
  localparam logic [2:0] ST_ABORTALL = 3'd5;

  // Reply codes
  localparam logic [2:0] RP_NONE = 3'd0;
  localparam logic [2:0] RP_ACK  = 3'd1;
  localparam logic [2:0] RP_NAK  = 3'd2;
  localparam logic [2:0] RP_CAN  = 3'd3;
  localparam logic [2:0] RP_ESC  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_DATA,
    PH_ETX,
    PH_CSUM,
    PH_MSG
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] line_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
    logic [2:0] reply;
  } result_t;

endpackage

// File: rtl/crr_chan_if.sv
// Valid/ready channel interfaces for the checksummed record receiver.
// crr_in_if carries input requests, crr_out_if carries result requests.
// Depends on nothing.
interface crr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] line_byte;

  modport source (output valid, output mode, output line_byte, input ready);
  modport sink (input valid, input mode, input line_byte, output ready);
endinterface

interface crr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [2:0] status;
  logic [2:0] reply;

  modport source (output valid, output kind, output value, output status, output reply,
                  input ready);
  modport sink (input valid, input kind, input value, input status, input reply,
                output ready);
endinterface

// File: rtl/checksummed_record_receiver_core.sv
// Top level of the checksummed record receiver.
// Input register, frame state machine and result register.
// Depends on crr_pkg, crr_chan_if and crr_frame_fsm.

// The receiver takes one request per clock while not stalled (a line byte, a timeout,
// an abort or a new-file mark) and gives at most one result per request: a tentative
// data byte, a message character, or a frame status with the reply byte to send back.
// A request is registered on entry in the input register and decoded there by the
// frame state machine; its result is loaded into the output register when both
// stages advance. Both stages advance together whenever the output register is
// empty or being taken, which sustains one request per cycle; back-pressure on the
// result side stalls input.
// A retry status tells downstream to drop the data bytes of that frame.
module checksummed_record_receiver_core (
  input logic      clk,
  input logic      rst,
  crr_in_if.sink   rx,
  crr_out_if.source res
);
  import crr_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_data;
  logic    step;
  logic    fsm_valid;
  result_t fsm_res;

  // Advance when the input register holds a request and the output register is free or drains this cycle
  assign step     = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_item <= '{mode: rx.mode, line_byte: rx.line_byte};
    end
  end

  crr_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (fsm_valid),
    .res       (fsm_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= fsm_valid;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && fsm_valid) begin
      out_data <= fsm_res;
    end
  end

  assign res.valid  = out_valid;
  assign res.kind   = out_data.kind;
  assign res.value  = out_data.value;
  assign res.status = out_data.status;
  assign res.reply  = out_data.reply;

endmodule

// File: rtl/crr_frame_fsm.sv
// Frame state machine of the checksummed record receiver.
// Holds frame phase, count, checksum and abort flags; decodes one request per step.
// Depends on crr_pkg.
module crr_frame_fsm (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  crr_pkg::item_t  item,
  output logic            res_valid,
  output crr_pkg::result_t res
);
  import crr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  count_high_byte, count_high_byte_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        abort_file_pending, abort_file_pending_next;
  logic        abort_all_pending, abort_all_pending_next;

  logic [7:0]  b;
  assign b = item.line_byte;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      bytes_left         <= '0;
      count_high_byte    <= '0;
      running_xor        <= '0;
      abort_file_pending <= 1'b0;
      abort_all_pending  <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      bytes_left         <= bytes_left_next;
      count_high_byte    <= count_high_byte_next;
      running_xor        <= running_xor_next;
      abort_file_pending <= abort_file_pending_next;
      abort_all_pending  <= abort_all_pending_next;
    end
  end

  // Decode the request against the current phase
  always_comb begin
    phase_next              = phase;
    bytes_left_next         = bytes_left;
    count_high_byte_next    = count_high_byte;
    running_xor_next        = running_xor;
    abort_file_pending_next = abort_file_pending;
    abort_all_pending_next  = abort_all_pending;
    res_valid               = 1'b0;
    res                     = '{kind: KIND_STATUS, value: 8'h00, status: ST_OK,
                                reply: RP_NONE};

    case (item.mode)
      MODE_TIMEOUT: begin
        // Only reads with a time limit fail the frame
        if (phase == PH_DATA || phase == PH_ETX || phase == PH_CSUM) begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res.status = ST_RETRY;
          res.reply  = RP_NAK;
        end
      end
      MODE_ABORT_FILE: abort_file_pending_next = 1'b1;
      MODE_ABORT_ALL:  abort_all_pending_next  = 1'b1;
      MODE_NEW_FILE: begin
        abort_file_pending_next = 1'b0;
        abort_all_pending_next  = 1'b0;
        phase_next              = PH_IDLE;
        bytes_left_next         = '0;
        running_xor_next        = '0;
      end
      MODE_BYTE: begin
        case (phase)
          PH_IDLE: begin
            if (b == CH_STX) begin
              running_xor_next = '0;
              phase_next       = PH_CNT_HI;
            end else if (b == CH_ESC) begin
              phase_next = PH_MSG;
            end else begin
              res_valid = 1'b1;
              if (b == CH_CAN) begin
                res.status = ST_EOF;
                res.reply  = RP_ACK;
              end else begin
                res.status = ST_CANCEL;
                res.reply  = RP_CAN;
              end
            end
          end
          PH_CNT_HI: begin
            count_high_byte_next = b;
            phase_next           = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            bytes_left_next = {count_high_byte, b};
            phase_next      = ({count_high_byte, b} == 16'd0) ? PH_ETX : PH_DATA;
          end
          PH_DATA: begin
            // Pass the byte on and fold it into the checksum
            running_xor_next = running_xor ^ b;
            bytes_left_next  = bytes_left - 16'd1;
            if (bytes_left == 16'd1) phase_next = PH_ETX;
            res_valid = 1'b1;
            res.kind  = KIND_DATA;
            res.value = b;
          end
          PH_ETX: begin
            if (b != CH_ETX) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_RETRY;
              res.reply  = RP_NAK;
            end else begin
              phase_next = PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            if (b != running_xor) begin
              res.status = ST_RETRY;
              res.reply  = RP_NAK;
            end else if (abort_file_pending) begin
              res.status = ST_CANCEL;
              res.reply  = RP_CAN;
            end else if (abort_all_pending) begin
              res.status = ST_ABORTALL;
              res.reply  = RP_ESC;
            end else begin
              res.status = ST_OK;
              res.reply  = RP_ACK;
            end
          end
          PH_MSG: begin
            res_valid = 1'b1;
            if (b == CH_ETX) begin
              phase_next = PH_IDLE;
              res.status = ST_MSGDONE;
              res.reply  = RP_NONE;
            end else begin
              res.kind  = KIND_MSG;
              res.value = b;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

endmodule
